>>> design/aabb_pkg.sv
//------------------------------------------------------------------------------
// aabb_pkg
// Shared types and constants of the transformed bounding box pipeline.
//------------------------------------------------------------------------------
package aabb_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned QuatW   = 16;
  localparam int unsigned MatW    = 32;
  localparam int unsigned ProdW   = MatW + CoordW;
  localparam int unsigned SumW    = ProdW + 2;
  localparam int unsigned MatFrac = 28;
  localparam int unsigned NumAxes = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int          QuatOne = 16384;

  typedef enum logic [CfgIdxW-1:0] {
    CfgShiftX = 3'd0,
    CfgShiftY = 3'd1,
    CfgShiftZ = 3'd2,
    CfgQuatW  = 3'd3,
    CfgQuatX  = 3'd4,
    CfgQuatY  = 3'd5,
    CfgQuatZ  = 3'd6
  } cfg_reg_e;

  typedef logic [NumAxes-1:0][CoordW-1:0]              coord_vec_t;
  typedef logic [NumAxes-1:0][NumAxes-1:0][MatW-1:0]   mat_t;
  typedef logic [NumAxes-1:0][NumAxes-1:0][ProdW-1:0]  prod_mat_t;
  typedef logic [NumAxes-1:0][SumW-1:0]                sum_vec_t;

  typedef struct packed {
    coord_vec_t lo;
    coord_vec_t hi;
  } box_t;

  typedef struct packed {
    prod_mat_t lo;
    prod_mat_t hi;
  } prod_pair_t;

  typedef struct packed {
    mat_t       mat;
    coord_vec_t shift;
  } pose_t;

endpackage

>>> design/aabb_cfg.sv
//------------------------------------------------------------------------------
// aabb_cfg
// Pose registers and rotation matrix build from the clamped quaternion.
//------------------------------------------------------------------------------
module aabb_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [aabb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  output aabb_pkg::pose_t             pose_o
);
  import aabb_pkg::*;

  coord_vec_t                          shift_q;
  logic [3:0][QuatW-1:0]               quat_q;
  mat_t                                mat_d, mat_q;
  logic signed [QuatW-1:0]             qw, qx, qy, qz;
  logic signed [2*QuatW-1:0]           xx, yy, zz, xy, xz, yz, wx, wy, wz;

  function automatic logic signed [QuatW-1:0] clamp_f(logic [QuatW-1:0] v);
    logic signed [QuatW-1:0] s;
    s = $signed(v);
    if (s > QuatW'(QuatOne)) return QuatW'(QuatOne);
    if (s < QuatW'(-QuatOne)) return QuatW'(-QuatOne);
    return s;
  endfunction

  function automatic logic [MatW-1:0] diag_f(logic signed [2*QuatW-1:0] a,
                                             logic signed [2*QuatW-1:0] b);
    logic signed [MatW+1:0] s;
    s = ((MatW+2)'(1) <<< MatFrac) - (((MatW+2)'(a) + (MatW+2)'(b)) <<< 1);
    return s[MatW-1:0];
  endfunction

  function automatic logic [MatW-1:0] offp_f(logic signed [2*QuatW-1:0] a,
                                             logic signed [2*QuatW-1:0] b);
    logic signed [MatW+1:0] s;
    s = ((MatW+2)'(a) + (MatW+2)'(b)) <<< 1;
    return s[MatW-1:0];
  endfunction

  function automatic logic [MatW-1:0] offm_f(logic signed [2*QuatW-1:0] a,
                                             logic signed [2*QuatW-1:0] b);
    logic signed [MatW+1:0] s;
    s = ((MatW+2)'(a) - (MatW+2)'(b)) <<< 1;
    return s[MatW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      quat_q  <= {QuatW'(0), QuatW'(0), QuatW'(0), QuatW'(QuatOne)};
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgShiftX: shift_q[0] <= cfg_data_i;
        CfgShiftY: shift_q[1] <= cfg_data_i;
        CfgShiftZ: shift_q[2] <= cfg_data_i;
        CfgQuatW:  quat_q[0]  <= cfg_data_i[QuatW-1:0];
        CfgQuatX:  quat_q[1]  <= cfg_data_i[QuatW-1:0];
        CfgQuatY:  quat_q[2]  <= cfg_data_i[QuatW-1:0];
        CfgQuatZ:  quat_q[3]  <= cfg_data_i[QuatW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    qw = clamp_f(quat_q[0]);
    qx = clamp_f(quat_q[1]);
    qy = clamp_f(quat_q[2]);
    qz = clamp_f(quat_q[3]);
    xx = (2*QuatW)'(qx) * (2*QuatW)'(qx);
    yy = (2*QuatW)'(qy) * (2*QuatW)'(qy);
    zz = (2*QuatW)'(qz) * (2*QuatW)'(qz);
    xy = (2*QuatW)'(qx) * (2*QuatW)'(qy);
    xz = (2*QuatW)'(qx) * (2*QuatW)'(qz);
    yz = (2*QuatW)'(qy) * (2*QuatW)'(qz);
    wx = (2*QuatW)'(qw) * (2*QuatW)'(qx);
    wy = (2*QuatW)'(qw) * (2*QuatW)'(qy);
    wz = (2*QuatW)'(qw) * (2*QuatW)'(qz);
    mat_d[0][0] = diag_f(yy, zz);
    mat_d[0][1] = offm_f(xy, wz);
    mat_d[0][2] = offp_f(xz, wy);
    mat_d[1][0] = offp_f(xy, wz);
    mat_d[1][1] = diag_f(xx, zz);
    mat_d[1][2] = offm_f(yz, wx);
    mat_d[2][0] = offm_f(xz, wy);
    mat_d[2][1] = offp_f(yz, wx);
    mat_d[2][2] = diag_f(xx, yy);
  end

  always_ff @(posedge clk_i) begin
    mat_q <= mat_d;
  end

  assign pose_o.mat   = mat_q;
  assign pose_o.shift = shift_q;

endmodule

>>> design/aabb_mul.sv
//------------------------------------------------------------------------------
// aabb_mul
// Input register and matrix-by-bound product stage.
//------------------------------------------------------------------------------
module aabb_mul (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  aabb_pkg::mat_t         mat_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  aabb_pkg::box_t         in_box_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output aabb_pkg::prod_pair_t   out_prod_o
);
  import aabb_pkg::*;

  logic       v1_q, v2_q;
  logic       rdy1, rdy2;
  box_t       box_q;
  prod_pair_t prod_d, prod_q;

  assign rdy2 = !v2_q || out_ready_i;
  assign rdy1 = !v1_q || rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      for (int j = 0; j < NumAxes; j++) begin
        prod_d.lo[k][j] = ProdW'($signed(mat_i[k][j])) * ProdW'($signed(box_q.lo[j]));
        prod_d.hi[k][j] = ProdW'($signed(mat_i[k][j])) * ProdW'($signed(box_q.hi[j]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) box_q <= in_box_i;
    if (rdy2 && v1_q) prod_q <= prod_d;
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = v2_q;
  assign out_prod_o  = prod_q;

endmodule

>>> design/aabb_bound.sv
//------------------------------------------------------------------------------
// aabb_bound
// Per-term extremes, row sums with translation, rounding and saturation.
//------------------------------------------------------------------------------
module aabb_bound (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  aabb_pkg::coord_vec_t  shift_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  aabb_pkg::prod_pair_t  in_prod_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output aabb_pkg::box_t        out_box_o
);
  import aabb_pkg::*;

  localparam logic signed [SumW-1:0] SatMax = (SumW'(1) <<< (CoordW-1)) - SumW'(1);
  localparam logic signed [SumW-1:0] SatMin = -(SumW'(1) <<< (CoordW-1));
  localparam logic signed [SumW-1:0] Half   = SumW'(1) <<< (MatFrac-1);

  logic       v3_q, v4_q, v5_q;
  logic       rdy3, rdy4, rdy5;
  prod_pair_t ext_d, ext_q;
  sum_vec_t   sum_lo_d, sum_hi_d, sum_lo_q, sum_hi_q;
  box_t       box_d, box_q;

  function automatic logic [CoordW-1:0] round_sat_f(logic [SumW-1:0] v);
    logic signed [SumW-1:0] t;
    t = ($signed(v) + Half) >>> MatFrac;
    if (t > SatMax) return SatMax[CoordW-1:0];
    if (t < SatMin) return SatMin[CoordW-1:0];
    return t[CoordW-1:0];
  endfunction

  function automatic logic ext_ok_f(prod_pair_t e);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < NumAxes; k++) begin
      for (int j = 0; j < NumAxes; j++) begin
        if ($signed(e.lo[k][j]) > $signed(e.hi[k][j])) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  assign rdy5 = !v5_q || out_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy3) v3_q <= in_valid_i;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      for (int j = 0; j < NumAxes; j++) begin
        if ($signed(in_prod_i.lo[k][j]) < $signed(in_prod_i.hi[k][j])) begin
          ext_d.lo[k][j] = in_prod_i.lo[k][j];
          ext_d.hi[k][j] = in_prod_i.hi[k][j];
        end else begin
          ext_d.lo[k][j] = in_prod_i.hi[k][j];
          ext_d.hi[k][j] = in_prod_i.lo[k][j];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      sum_lo_d[k] = SumW'($signed(ext_q.lo[k][0])) + SumW'($signed(ext_q.lo[k][1]))
                  + SumW'($signed(ext_q.lo[k][2]))
                  + (SumW'($signed(shift_i[k])) <<< MatFrac);
      sum_hi_d[k] = SumW'($signed(ext_q.hi[k][0])) + SumW'($signed(ext_q.hi[k][1]))
                  + SumW'($signed(ext_q.hi[k][2]))
                  + (SumW'($signed(shift_i[k])) <<< MatFrac);
    end
  end

  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      box_d.lo[k] = round_sat_f(sum_lo_q[k]);
      box_d.hi[k] = round_sat_f(sum_hi_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && in_valid_i) ext_q <= ext_d;
    if (rdy4 && v3_q) begin
      sum_lo_q <= sum_lo_d;
      sum_hi_q <= sum_hi_d;
    end
    if (rdy5 && v4_q) box_q <= box_d;
  end

  assign in_ready_o  = rdy3;
  assign out_valid_o = v5_q;
  assign out_box_o   = box_q;

  a_ext_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> ext_ok_f(ext_q))
    else $error("term extremes out of order");

  a_sum_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> ($signed(sum_lo_q[0]) <= $signed(sum_hi_q[0])) &&
             ($signed(sum_lo_q[1]) <= $signed(sum_hi_q[1])) &&
             ($signed(sum_lo_q[2]) <= $signed(sum_hi_q[2])))
    else $error("row sums out of order");

  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> ($signed(box_q.lo[0]) <= $signed(box_q.hi[0])) &&
             ($signed(box_q.lo[1]) <= $signed(box_q.hi[1])) &&
             ($signed(box_q.lo[2]) <= $signed(box_q.hi[2])))
    else $error("result box lower bound above upper bound");

endmodule

>>> design/aabb_pose_transform.sv
//------------------------------------------------------------------------------
// aabb_pose_transform
// Moves an axis-aligned box by a rotation quaternion and a translation and
// returns the axis-aligned box of the moved corners.
//
//   channel  direction  handshake                 payload
//   s_axis   in         s_axis_tvalid/tready      6 x Q16.16 box bounds
//   m_axis   out        m_axis_tvalid/tready      6 x Q16.16 box bounds
//   cfg      in         cfg_valid_i/cfg_ready_o   register index, write data
//
// One box per cycle while m_axis is not stalled and no cfg write is pending; each
// box passes the input, product, extreme, sum and rounding register stages.
// Each stage holds while the one after it is full and stalled.
// Reset clears valid bits and loads the identity pose; no clearing pass.
// A register write reaches the rotation matrix through the quaternion register and then the matrix register.
//------------------------------------------------------------------------------
module aabb_pose_transform (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z
  input  logic [191:0]                  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
  output logic [191:0]                  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [aabb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import aabb_pkg::*;

  pose_t      pose;
  box_t       in_box, out_box;
  prod_pair_t prod;
  logic       mul_in_ready, mul_valid, bnd_ready;

  always_comb begin
    for (int j = 0; j < NumAxes; j++) begin
      in_box.lo[j] = s_axis_tdata[CoordW*j +: CoordW];
      in_box.hi[j] = s_axis_tdata[CoordW*(j+NumAxes) +: CoordW];
      m_axis_tdata[CoordW*j +: CoordW]           = out_box.lo[j];
      m_axis_tdata[CoordW*(j+NumAxes) +: CoordW] = out_box.hi[j];
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = mul_in_ready && !cfg_valid_i;

  aabb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pose_o      (pose)
  );

  aabb_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mat_i       (pose.mat),
    .in_valid_i  (s_axis_tvalid && !cfg_valid_i),
    .in_ready_o  (mul_in_ready),
    .in_box_i    (in_box),
    .out_valid_o (mul_valid),
    .out_ready_i (bnd_ready),
    .out_prod_o  (prod)
  );

  aabb_bound u_bound (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (pose.shift),
    .in_valid_i  (mul_valid),
    .in_ready_o  (bnd_ready),
    .in_prod_i   (prod),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_box_o   (out_box)
  );

endmodule

>>> dv/aabb_pose_transform_tb.sv
//------------------------------------------------------------------------------
// aabb_pose_transform_tb
// Streams boxes through the pose transform and checks every moved box
// against an exact fixed-point model of the rotation, translation, rounding
// and saturation, or against a fixed expected box for pinned table rows. A
// directed table covers the identity pose, bound extremes, swapped bounds,
// saturation, clamped and non-unit quaternions and a write to an unused
// register index. Random phases follow, each with a new pose. Both stream
// sides stall at random.
module aabb_pose_transform_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aabb_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgNoReg   = 3'd7;
  localparam int                 CMax       = 32'h7FFF_FFFF;
  localparam int                 CMin       = 32'h8000_0000;
  localparam logic signed [79:0] SatHi      = 80'sd2147483647;
  localparam logic signed [79:0] SatLo      = -80'sd2147483648;
  localparam int                 StallLimit = 4000;
  localparam int                 DrainWait  = 20;
  localparam int                 PoseSettle = 8;
  localparam int                 NumPhases  = 11;
  localparam int                 PhaseBoxes = 50;

  typedef struct packed {
    coord_vec_t hi;
    coord_vec_t lo;
  } bounds_t;

  typedef struct {
    bit                 is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [31:0]        data;
    bounds_t            box;
    bit                 pinned;
    bounds_t            want;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [191:0]       s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [191:0]       m_axis_tdata;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [31:0]        cfg_data_i;

  logic signed [31:0] pose_shift [3];
  logic signed [15:0] pose_quat  [4];
  bounds_t            moved_boxes [$];
  bit                 pin_on;
  bounds_t            pin_box;
  bit                 no_gaps;
  int                 n_err;
  int                 idle_cycles;
  string              axis_name [3] = '{"x", "y", "z"};

  aabb_pose_transform dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bounds_t move_box(bounds_t b);
    logic signed [79:0] q [4];
    logic signed [79:0] m [3][3];
    logic signed [79:0] p [3];
    logic signed [79:0] sh [3];
    logic signed [79:0] one, half, acc;
    logic signed [31:0] v;
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    bounds_t o;
    int i, c, k;
    for (i = 0; i < 4; i++) begin
      q[i] = 80'(pose_quat[i]);
      if (q[i] > 80'(QuatOne)) q[i] = 80'(QuatOne);
      if (q[i] < 80'(-QuatOne)) q[i] = 80'(-QuatOne);
    end
    for (k = 0; k < 3; k++) sh[k] = 80'(pose_shift[k]);
    one  = 80'sd1 <<< MatFrac;
    half = 80'sd1 <<< (MatFrac - 1);
    // q: w, x, y, z
    m[0][0] = one - 2 * (q[2] * q[2] + q[3] * q[3]);
    m[0][1] = 2 * (q[1] * q[2] - q[0] * q[3]);
    m[0][2] = 2 * (q[1] * q[3] + q[0] * q[2]);
    m[1][0] = 2 * (q[1] * q[2] + q[0] * q[3]);
    m[1][1] = one - 2 * (q[1] * q[1] + q[3] * q[3]);
    m[1][2] = 2 * (q[2] * q[3] - q[0] * q[1]);
    m[2][0] = 2 * (q[1] * q[3] - q[0] * q[2]);
    m[2][1] = 2 * (q[2] * q[3] + q[0] * q[1]);
    m[2][2] = one - 2 * (q[1] * q[1] + q[2] * q[2]);
    for (c = 0; c < 8; c++) begin
      p[0] = 80'((c & 1) ? $signed(b.hi[0]) : $signed(b.lo[0]));
      p[1] = 80'((c & 2) ? $signed(b.hi[1]) : $signed(b.lo[1]));
      p[2] = 80'((c & 4) ? $signed(b.hi[2]) : $signed(b.lo[2]));
      for (k = 0; k < 3; k++) begin
        acc = m[k][0] * p[0] + m[k][1] * p[1] + m[k][2] * p[2] + (sh[k] <<< MatFrac) + half;
        acc = acc >>> MatFrac;
        if (acc > SatHi) v = CMax;
        else if (acc < SatLo) v = CMin;
        else v = acc[31:0];
        if (c == 0 || v < lo[k]) lo[k] = v;
        if (c == 0 || v > hi[k]) hi[k] = v;
      end
    end
    for (k = 0; k < 3; k++) begin
      o.lo[k] = lo[k];
      o.hi[k] = hi[k];
    end
    return o;
  endfunction

  always @(posedge clk_i) begin : monitor
    bounds_t got, want;
    int k;
    if (!rst_ni) begin
      pose_shift = '{0, 0, 0};
      pose_quat  = '{16'(QuatOne), '0, '0, '0};
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgShiftX: pose_shift[0] = cfg_data_i;
          CfgShiftY: pose_shift[1] = cfg_data_i;
          CfgShiftZ: pose_shift[2] = cfg_data_i;
          CfgQuatW:  pose_quat[0]  = cfg_data_i[15:0];
          CfgQuatX:  pose_quat[1]  = cfg_data_i[15:0];
          CfgQuatY:  pose_quat[2]  = cfg_data_i[15:0];
          CfgQuatZ:  pose_quat[3]  = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        moved_boxes.insert(moved_boxes.size(),
                           pin_on ? pin_box : move_box(bounds_t'(s_axis_tdata)));
      if (m_axis_tvalid && m_axis_tready) begin
        got = bounds_t'(m_axis_tdata);
        if (moved_boxes.size() == 0) begin
          n_err++;
          $error("result with no box pending: %h", m_axis_tdata);
        end else begin
          want = moved_boxes.pop_front();
          for (k = 0; k < 3; k++) begin
            if (got.lo[k] !== want.lo[k]) begin
              n_err++;
              $error("out_min_%s: expected %0d, got %0d", axis_name[k],
                     $signed(want.lo[k]), $signed(got.lo[k]));
            end
            if (got.hi[k] !== want.hi[k]) begin
              n_err++;
              $error("out_max_%s: expected %0d, got %0d", axis_name[k],
                     $signed(want.hi[k]), $signed(got.hi[k]));
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == StallLimit) begin
      $display("aabb_pose_transform_tb: errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    int gap;
    m_axis_tready = 1'b0;
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        @(negedge clk_i) m_axis_tready = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i) m_axis_tready = 1'b1;
      repeat ($urandom_range(0, 7)) @(negedge clk_i);
    end
  end

  function automatic bounds_t corners(int lx, int ly, int lz, int hx, int hy, int hz);
    bounds_t o;
    o.lo[0] = lx;
    o.lo[1] = ly;
    o.lo[2] = lz;
    o.hi[0] = hx;
    o.hi[1] = hy;
    o.hi[2] = hz;
    return o;
  endfunction

  function automatic plan_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic plan_row_t box_row(bounds_t box);
    plan_row_t r;
    r = '{default: '0};
    r.box = box;
    return r;
  endfunction

  function automatic plan_row_t pin_row(bounds_t box, bounds_t want);
    plan_row_t r;
    r = box_row(box);
    r.pinned = 1'b1;
    r.want   = want;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 19))
      0:       return CMin;
      1:       return CMax;
      2:       return '0;
      3:       return '1;
      4, 5, 6: return $urandom();
      default: return $urandom_range(0, 33554432) - 16777216;
    endcase
  endfunction

  function automatic logic [31:0] rand_shift();
    case ($urandom_range(0, 9))
      0:       return CMax;
      1:       return CMin;
      2:       return '0;
      3:       return $urandom();
      default: return $urandom_range(0, 33554432) - 16777216;
    endcase
  endfunction

  function automatic bounds_t rand_box();
    bounds_t o;
    logic [31:0] a, c;
    bit ordered;
    int k;
    ordered = ($urandom_range(0, 4) != 0);
    for (k = 0; k < 3; k++) begin
      a = rand_coord();
      c = rand_coord();
      if (ordered && $signed(a) > $signed(c)) begin
        o.lo[k] = c;
        o.hi[k] = a;
      end else begin
        o.lo[k] = a;
        o.hi[k] = c;
      end
    end
    return o;
  endfunction

  task automatic push_box(bounds_t box, bit pinned, bounds_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = box;
    pin_on        = pinned;
    pin_box       = want;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic stop_boxes();
    @(negedge clk_i) s_axis_tvalid = 1'b0;
  endtask

  task automatic settle();
    while (moved_boxes.size() != 0) @(posedge clk_i);
    repeat (PoseSettle) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i) cfg_valid_i = 1'b0;
  endtask

  initial begin
    plan_row_t   plan [$];
    logic [31:0] qv [4];
    bounds_t     full, alt, odd;
    int          ph, i;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    pin_on        = 1'b0;
    pin_box       = '0;
    no_gaps       = 1'b0;
    n_err         = 0;
    idle_cycles   = 0;

    full = corners(CMin, CMin, CMin, CMax, CMax, CMax);
    alt  = corners(32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                   32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    odd  = corners(7, -8, 9, 10, 11, -12);

    plan.insert(plan.size(), pin_row(corners(0, 0, 0, 0, 0, 0), corners(0, 0, 0, 0, 0, 0)));
    plan.insert(plan.size(), pin_row(full, full));
    plan.insert(plan.size(),
                pin_row(corners(5 << 16, 6 << 16, 7 << 16,
                                -(1 << 16), -(2 << 16), -(3 << 16)),
                        corners(-(1 << 16), -(2 << 16), -(3 << 16),
                                5 << 16, 6 << 16, 7 << 16)));
    plan.insert(plan.size(),
                pin_row(alt, corners(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                     32'h5555_5555, 32'h5555_5555, 32'h5555_5555)));
    // saturate the translated result on x and y
    plan.insert(plan.size(), cfg_row(CfgShiftX, CMax));
    plan.insert(plan.size(), cfg_row(CfgShiftY, CMin));
    plan.insert(plan.size(), cfg_row(CfgShiftZ, 32'h0001_0000));
    plan.insert(plan.size(), pin_row(corners(1, -1, 0, CMax, 0, 5),
                                     corners(CMax, CMin, 65536, CMax, CMin, 65541)));
    plan.insert(plan.size(), box_row(corners(-70000, 123456, -1, 5, CMax, CMin)));
    plan.insert(plan.size(), cfg_row(CfgShiftX, 0));
    plan.insert(plan.size(), cfg_row(CfgShiftY, 0));
    plan.insert(plan.size(), cfg_row(CfgShiftZ, 0));
    // half turn about z
    plan.insert(plan.size(), cfg_row(CfgQuatW, 0));
    plan.insert(plan.size(), cfg_row(CfgQuatZ, QuatOne));
    plan.insert(plan.size(),
                pin_row(corners(1 << 16, 2 << 16, 3 << 16, 4 << 16, 5 << 16, 6 << 16),
                        corners(-(4 << 16), -(5 << 16), 3 << 16,
                                -(1 << 16), -(2 << 16), 6 << 16)));
    plan.insert(plan.size(),
                pin_row(full, corners(-2147483647, -2147483647, CMin, CMax, CMax, CMax)));
    // out-of-range scalar part clamps back to identity
    plan.insert(plan.size(), cfg_row(CfgQuatZ, 0));
    plan.insert(plan.size(), cfg_row(CfgQuatW, 32'h0000_7FFF));
    plan.insert(plan.size(), pin_row(odd, corners(7, -8, -12, 10, 11, 9)));
    plan.insert(plan.size(), cfg_row(CfgQuatW, 32'h0000_8000));
    plan.insert(plan.size(), pin_row(full, full));
    // all-zero quaternion leaves the unit matrix
    plan.insert(plan.size(), cfg_row(CfgQuatW, 32'hFFFF_0000));
    plan.insert(plan.size(), pin_row(odd, corners(7, -8, -12, 10, 11, 9)));
    plan.insert(plan.size(), cfg_row(CfgNoReg, 32'hFFFF_FFFF));
    plan.insert(plan.size(),
                pin_row(corners(-1, -1, -1, 0, 0, 0), corners(-1, -1, -1, 0, 0, 0)));
    // non-unit quaternions shear and scale
    plan.insert(plan.size(), cfg_row(CfgQuatX, 32'h2000));
    plan.insert(plan.size(), cfg_row(CfgQuatY, 32'h2000));
    plan.insert(plan.size(), cfg_row(CfgQuatZ, 32'h2000));
    plan.insert(plan.size(),
                box_row(corners(100000, -200000, 300000, 400000, 500000, 600000)));
    plan.insert(plan.size(), box_row(full));
    plan.insert(plan.size(), cfg_row(CfgQuatW, QuatOne));
    plan.insert(plan.size(), cfg_row(CfgQuatX, QuatOne));
    plan.insert(plan.size(), cfg_row(CfgQuatY, QuatOne));
    plan.insert(plan.size(), cfg_row(CfgQuatZ, QuatOne));
    plan.insert(plan.size(),
                box_row(corners(-3 << 16, 1 << 16, -5, 2 << 16, 9 << 16, 77)));
    plan.insert(plan.size(), box_row(alt));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    foreach (plan[n]) begin
      if (plan[n].is_cfg) begin
        stop_boxes();
        settle();
        cfg_write(plan[n].idx, plan[n].data);
      end else begin
        push_box(plan[n].box, plan[n].pinned, plan[n].want);
      end
    end

    for (ph = 0; ph < NumPhases; ph++) begin
      stop_boxes();
      settle();
      no_gaps = ($urandom_range(0, 3) == 0);
      cfg_write(CfgShiftX, rand_shift());
      cfg_write(CfgShiftY, rand_shift());
      cfg_write(CfgShiftZ, rand_shift());
      case ($urandom_range(0, 3))
        0: for (i = 0; i < 4; i++) qv[i] = $urandom();
        1: for (i = 0; i < 4; i++) qv[i] = $urandom_range(0, 1) ? 8192 : -8192;
        2: begin
          for (i = 0; i < 4; i++) qv[i] = 0;
          qv[$urandom_range(0, 3)] = $urandom_range(0, 1) ? QuatOne : -QuatOne;
        end
        default: for (i = 0; i < 4; i++) qv[i] = $urandom_range(0, 32768) - 16384;
      endcase
      cfg_write(CfgQuatW, qv[0]);
      cfg_write(CfgQuatX, qv[1]);
      cfg_write(CfgQuatY, qv[2]);
      cfg_write(CfgQuatZ, qv[3]);
      if ($urandom_range(0, 3) == 0) cfg_write(CfgNoReg, $urandom());
      repeat (PhaseBoxes) push_box(rand_box(), 1'b0, '0);
    end

    stop_boxes();
    while (moved_boxes.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (n_err == 0 && moved_boxes.size() == 0)
      $display("aabb_pose_transform_tb: clean");
    else
      $display("aabb_pose_transform_tb: errors");
    $finish;
  end

endmodule
